/* hw/rtl/mhd_pkg.sv */
package mhd_pkg;

  // CORDIC iteration count, limited to the tabulated steps
  localparam int CORDIC_STEPS = 16;
  localparam int TBL_DEPTH    = 24;
  localparam int STEP_COUNT   = (CORDIC_STEPS > TBL_DEPTH) ? TBL_DEPTH : CORDIC_STEPS;
  localparam int STEP_W       = $clog2(STEP_COUNT);
  localparam int TBL_IDX_W    = $clog2(TBL_DEPTH);

  // Datapath widths
  localparam int WORD_W  = 16;
  localparam int FRAC_SH = 8;
  localparam int XY_W    = 27;
  localparam int ACC_W   = 26;
  localparam int TBL_W   = 23;
  localparam int DEG_W   = 9;
  localparam int ACC_SH  = 16;

  // Angle constants in degrees and in accumulator units
  localparam logic [DEG_W-1:0] DEG_0   = DEG_W'(0);
  localparam logic [DEG_W-1:0] DEG_90  = DEG_W'(90);
  localparam logic [DEG_W-1:0] DEG_180 = DEG_W'(180);
  localparam logic [DEG_W-1:0] DEG_270 = DEG_W'(270);
  localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(359);
  localparam logic signed [ACC_W-1:0] ACC_180 = ACC_W'(180 * 65536);
  localparam logic signed [ACC_W-1:0] ACC_360 = ACC_W'(360 * 65536);

  // Byte positions within the read burst
  localparam logic [2:0] POS_XH   = 3'd0;
  localparam logic [2:0] POS_XL   = 3'd1;
  localparam logic [2:0] POS_ZH   = 3'd2;
  localparam logic [2:0] POS_ZL   = 3'd3;
  localparam logic [2:0] POS_YH   = 3'd4;
  localparam logic [2:0] POS_YL   = 3'd5;

  // atan(2^-i) in degrees, scaled by 65536
  localparam logic [TBL_W-1:0] ATAN_TBL [TBL_DEPTH] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666,   23'd29335,   23'd14668,  23'd7334,   23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,    23'd57,     23'd29,
    23'd14,      23'd7,       23'd4,      23'd2,      23'd1,      23'd0
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } cordic_state_t;

  // Completed burst handed to the CORDIC unit
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] x_word;
    logic [WORD_W-1:0] y_word;
  } sample_t;

endpackage

/* hw/rtl/magnetometer_heading_atan2.sv */
// Compass heading from a six-byte magnetometer burst, CORDIC vectoring.
// Flow: the Y low byte starts a run of CORDIC_STEPS iterations, then a finish
// state that loads the output register; axis and zero vectors skip the run.
// Throughput: one byte per cycle while idle; in_ready drops through a run and its finish,
// set by the single shared shift-add unit, and stays low while a result still waits.
// Reset (rst, synchronous): byte count to X high, stored bytes cleared, no result pending.
module magnetometer_heading_atan2 (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [7:0]                   data_byte,
  input  logic                         frame_start,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic [mhd_pkg::DEG_W-1:0]    heading_deg,
  output logic                         out_valid,
  input  logic                         out_ready
);
  import mhd_pkg::*;

  sample_t sample;
  logic    idle;
  logic    accept;

  // Take a byte only while the CORDIC unit is free
  assign in_ready = idle;
  assign accept   = in_valid && in_ready;

  mhd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .sample      (sample)
  );

  mhd_cordic u_cordic (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .idle        (idle),
    .heading_deg (heading_deg),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule

/* hw/rtl/mhd_frame.sv */
module mhd_frame (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [7:0]                   data_byte,
  input  logic                         frame_start,
  output mhd_pkg::sample_t             sample
);
  import mhd_pkg::*;

  logic [2:0]        byte_count;
  logic [2:0]        byte_count_next;
  logic [WORD_W-1:0] x_value;
  logic [7:0]        y_high_byte;
  logic [2:0]        idx;

  // Pick the burst position; frame start or an out-of-range count restarts at X high
  always_comb begin
    if (frame_start || byte_count > POS_YL) begin
      idx = POS_XH;
    end else begin
      idx = byte_count;
    end
    if (idx == POS_YL) begin
      byte_count_next = POS_XH;
    end else begin
      byte_count_next = idx + 3'd1;
    end
  end

  // Advance the count and capture X and the Y high byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= POS_XH;
      x_value     <= '0;
      y_high_byte <= '0;
    end else if (accept) begin
      byte_count <= byte_count_next;
      case (idx)
        POS_XH:  x_value     <= {data_byte, 8'h00};
        POS_XL:  x_value     <= {x_value[WORD_W-1:8], data_byte};
        POS_YH:  y_high_byte <= data_byte;
        default: ;
      endcase
    end
  end

  // Hand the full sample over with the Y low byte
  assign sample.start  = accept && (idx == POS_YL);
  assign sample.x_word = x_value;
  assign sample.y_word = {y_high_byte, data_byte};

endmodule

/* hw/rtl/mhd_cordic.sv */
module mhd_cordic (
  input  logic                         clk,
  input  logic                         rst,
  input  mhd_pkg::sample_t             sample,
  output logic                         idle,
  output logic [mhd_pkg::DEG_W-1:0]    heading_deg,
  output logic                         out_valid,
  input  logic                         out_ready
);
  import mhd_pkg::*;

  cordic_state_t               state;
  cordic_state_t               state_next;
  logic [STEP_W-1:0]           step;
  logic signed [XY_W-1:0]      x;
  logic signed [XY_W-1:0]      y;
  logic signed [ACC_W-1:0]     acc;
  logic                        axis;
  logic [DEG_W-1:0]            axis_deg;

  logic signed [XY_W-1:0]      x_ext;
  logic signed [XY_W-1:0]      y_ext;
  logic signed [XY_W-1:0]      x_sh;
  logic signed [XY_W-1:0]      y_sh;
  logic signed [ACC_W-1:0]     tbl;
  logic signed [ACC_W-1:0]     acc_wrap;
  logic [ACC_W-ACC_SH-1:0]     deg_raw;
  logic [DEG_W-1:0]            deg_final;
  logic                        last_step;
  logic                        slot_free;

  // Scale the inputs by 256 with sign extension
  assign x_ext = {{(XY_W-WORD_W-FRAC_SH){sample.x_word[WORD_W-1]}}, sample.x_word,
                  {FRAC_SH{1'b0}}};
  assign y_ext = {{(XY_W-WORD_W-FRAC_SH){sample.y_word[WORD_W-1]}}, sample.y_word,
                  {FRAC_SH{1'b0}}};

  // Shared shifter and angle table lookup for the current step
  assign x_sh = x >>> step;
  assign y_sh = y >>> step;
  assign tbl  = ACC_W'(ATAN_TBL[TBL_IDX_W'(step)]);

  assign last_step = (step == STEP_W'(STEP_COUNT - 1));
  assign slot_free = !out_valid || out_ready;

  // Wrap negative angles, truncate to degrees and clamp
  always_comb begin
    if (acc < 0) begin
      acc_wrap = acc + ACC_360;
    end else begin
      acc_wrap = acc;
    end
    deg_raw = acc_wrap[ACC_W-1:ACC_SH];
    if (axis) begin
      deg_final = axis_deg;
    end else if (deg_raw > (ACC_W-ACC_SH)'(DEG_MAX)) begin
      deg_final = DEG_MAX;
    end else begin
      deg_final = deg_raw[DEG_W-1:0];
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample.start) begin
          if (sample.x_word == '0 || sample.y_word == '0) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (last_step) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load operands, then iterate one micro-rotation per cycle
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        step <= '0;
        axis <= (sample.x_word == '0) || (sample.y_word == '0);
        if (sample.y_word == '0) begin
          axis_deg <= sample.x_word[WORD_W-1] ? DEG_180 : DEG_0;
        end else begin
          axis_deg <= sample.y_word[WORD_W-1] ? DEG_270 : DEG_90;
        end
        if (sample.x_word[WORD_W-1]) begin
          x   <= -x_ext;
          y   <= -y_ext;
          acc <= ACC_180;
        end else begin
          x   <= x_ext;
          y   <= y_ext;
          acc <= '0;
        end
      end
      ST_RUN: begin
        step <= step + STEP_W'(1);
        if (y != '0) begin
          if (y[XY_W-1]) begin
            x   <= x - y_sh;
            y   <= y + x_sh;
            acc <= acc - tbl;
          end else begin
            x   <= x + y_sh;
            y   <= y - x_sh;
            acc <= acc + tbl;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: load the heading when the slot frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && slot_free) begin
      heading_deg <= deg_final;
    end
  end

  assign idle = (state == ST_IDLE);

  // A burst only starts a run while the unit is idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    sample.start |-> state == ST_IDLE)
    else $error("sample started while CORDIC busy");

  // The last step always moves on to the finish state
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && last_step) |=> state == ST_FINISH)
    else $error("run did not end after last step");

  // A new result only comes from the finish state
  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside finish");

  // Headings stay within a full turn
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> heading_deg <= DEG_MAX)
    else $error("heading out of range");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import mhd_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       fs;
  } beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic [7:0]       data_byte = 8'h00;
  logic             frame_start = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [DEG_W-1:0] heading_deg;
  logic             out_valid;
  logic             out_ready = 1'b0;

  beat_t            pending_beats[$];
  logic [DEG_W-1:0] expected_headings[$];
  int               beats_total;
  int               beats_taken;
  int               errors;

  // Burst tracking state, mirrors what the block keeps between beats
  logic [2:0]       burst_pos;
  logic [15:0]      x_word;
  logic [7:0]       y_high;

  beat_t            next_beat;
  logic [DEG_W-1:0] want_heading;

  magnetometer_heading_atan2 u_top (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .frame_start(frame_start),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .heading_deg(heading_deg),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  always #1 clk = ~clk;

  // Heading of the vector (xw, yw) by fixed-point CORDIC vectoring
  function automatic logic [DEG_W-1:0] calc_heading(input logic [15:0] xw,
                                                    input logic [15:0] yw);
    longint xs, ys, x, y, nx, ny, acc;
    bit     done;
    if (yw == 16'h0000) return xw[15] ? DEG_180 : DEG_0;
    if (xw == 16'h0000) return yw[15] ? DEG_270 : DEG_90;
    xs = longint'($signed(xw));
    ys = longint'($signed(yw));
    x = xs * 256;
    y = ys * 256;
    acc = 0;
    done = 1'b0;
    // rotate the left half-plane onto the right one
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = longint'(ACC_180);
    end
    for (int i = 0; i < STEP_COUNT && !done; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        acc += longint'(ATAN_TBL[i]);
        x = nx;
        y = ny;
      end else if (y < 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        acc -= longint'(ATAN_TBL[i]);
        x = nx;
        y = ny;
      end else begin
        done = 1'b1;
      end
    end
    if (acc < 0) acc += longint'(ACC_360);
    if (acc < 0) acc = 0;
    acc = acc >>> ACC_SH;
    if (acc > 359) return DEG_MAX;
    return acc[DEG_W-1:0];
  endfunction

  // Advance the burst position for one accepted beat
  task automatic take_beat(input logic [7:0] b, input logic fs);
    logic [2:0] pos;
    pos = fs ? POS_XH : burst_pos;
    if (pos > POS_YL) pos = POS_XH;
    case (pos)
      POS_XH: x_word = {b, 8'h00};
      POS_XL: x_word[7:0] = b;
      POS_YH: y_high = b;
      POS_YL: expected_headings.push_back(calc_heading(x_word, {y_high, b}));
      default: ;
    endcase
    burst_pos = (pos == POS_YL) ? POS_XH : pos + 3'd1;
  endtask

  task automatic push_beat(input logic [7:0] b, input logic fs);
    beat_t bt;
    bt.data = b;
    bt.fs = fs;
    pending_beats.push_back(bt);
  endtask

  // Queue a full burst: X high, X low, Z high, Z low, Y high, Y low
  task automatic push_burst(input logic [15:0] xw, input logic [15:0] yw, input logic fs);
    push_beat(xw[15:8], fs);
    push_beat(xw[7:0], 1'b0);
    push_beat(8'($urandom_range(255)), 1'b0);
    push_beat(8'($urandom_range(255)), 1'b0);
    push_beat(yw[15:8], 1'b0);
    push_beat(yw[7:0], 1'b0);
  endtask

  // Mostly corner values, the rest uniform
  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      5: return 16'($signed($urandom_range(31)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  // Idle percentages per phase: sender-light, receiver-light, then none
  function automatic int send_idle_pct();
    if (beats_taken * 3 < beats_total) return 20;
    if (beats_taken * 3 < beats_total * 2) return 60;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (beats_taken * 3 < beats_total) return 60;
    if (beats_taken * 3 < beats_total * 2) return 20;
    return 0;
  endfunction

  // Driver: hold a beat until accepted, then offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        take_beat(data_byte, frame_start);
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          next_beat = pending_beats.pop_front();
          data_byte <= next_beat.data;
          frame_start <= next_beat.fs;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expected heading
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_headings.size() == 0) begin
          $error("heading_deg: no result expected, got %0d", heading_deg);
          errors++;
        end else begin
          want_heading = expected_headings.pop_front();
          if (heading_deg !== want_heading) begin
            $error("heading_deg: expected %0d, got %0d", want_heading, heading_deg);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  initial begin
    int n;
    burst_pos = POS_XH;
    x_word = 16'h0000;
    y_high = 8'h00;
    beats_taken = 0;
    errors = 0;

    // Directed: zero vector, positive X axis counted without frame start,
    // negative Y axis at full scale, restart mid-burst, extreme corners
    push_burst(16'h0000, 16'h0000, 1'b1);
    push_burst(16'h1234, 16'h0000, 1'b0);
    push_burst(16'h0000, 16'h8000, 1'b1);
    push_beat(8'hFF, 1'b1);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hAA, 1'b0);
    push_burst(16'h8000, 16'h7FFF, 1'b1);

    // Random: mostly well-formed bursts, some noise and broken bursts
    while (pending_beats.size() < 1050) begin
      if ($urandom_range(99) < 85) begin
        push_burst(pick_word(), pick_word(), $urandom_range(99) < 75);
      end else begin
        n = $urandom_range(5, 1);
        repeat (n) push_beat(8'($urandom_range(255)), $urandom_range(3) == 0);
      end
    end
    beats_total = pending_beats.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Drain: all beats taken, all results seen, then a quiet tail
    while (beats_taken < beats_total) @(negedge clk);
    while (expected_headings.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mhd_pkg.sv
hw/rtl/mhd_frame.sv
hw/rtl/mhd_cordic.sv
hw/rtl/magnetometer_heading_atan2.sv
bench/tb.sv
